// ===== design/skm_pkg.sv =====
// ----------------------------------------------------------------------------
// skm_pkg
// Shared types, sizes and codes of the skyline matrix store.
// ----------------------------------------------------------------------------
`default_nettype none

package skm_pkg;

    localparam int MAX_SIZE   = 64;
    localparam int WORD_BITS  = 64;
    localparam int PACK_DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;

    localparam int IDX_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int PACK_AW = $clog2(PACK_DEPTH);
    localparam int BASE_W  = $clog2(PACK_DEPTH + 1);
    localparam int INFO_W  = BASE_W + IDX_W;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [63:0]        t_word;
    typedef logic [1:0]         t_err;
    typedef logic [BASE_W-1:0]  t_base;
    typedef logic [PACK_AW-1:0] t_paddr;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam t_err ERR_OK        = 2'd0;
    localparam t_err ERR_RANGE     = 2'd1;
    localparam t_err ERR_UNLOADED  = 2'd2;
    localparam t_err ERR_ORDER     = 2'd3;

    // plus or minus zero: all bits below the sign bit are clear
    function automatic logic word_is_zero(input t_word v);
        return v[WORD_BITS-2:0] == '0;
    endfunction

endpackage

`default_nettype wire

// ===== design/skm_channels.sv =====
// ----------------------------------------------------------------------------
// skm_channels
// Valid/ready channels of the skyline matrix store: item in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface skm_item_if;
    import skm_pkg::*;

    logic  valid;
    logic  ready;
    logic  action;
    t_idx  row_index;
    t_idx  col_index;
    t_word element_value;

    modport source (output valid, action, row_index, col_index, element_value,
                    input ready);
    modport sink   (input valid, action, row_index, col_index, element_value,
                    output ready);
endinterface

interface skm_result_if;
    import skm_pkg::*;

    logic  valid;
    logic  ready;
    t_word read_value;
    t_err  error_code;

    modport source (output valid, read_value, error_code, input ready);
    modport sink   (input valid, read_value, error_code, output ready);
endinterface

`default_nettype wire

// ===== design/skm_ram.sv =====
// ----------------------------------------------------------------------------
// skm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/skyline_matrix_store.sv =====
// ----------------------------------------------------------------------------
// skyline_matrix_store
// Skyline (profile) storage of a symmetric matrix with element lookup.
//
// Input transactions on i_item carry a load (action 0: next upper-triangle
// element, column by column, row 0 down to the diagonal) or a lookup
// (action 1). Every input transaction yields exactly one output transaction
// on o_result with read_value and error_code.
// Loads and rejected items return their result in the cycle after acceptance,
// and a new item may follow every cycle while results are taken. A valid
// lookup reads the column info RAM, then the packed value RAM, passing
// through ST_INFO and ST_DATA before its result is registered; no new item is taken meanwhile.
// The result sits in an output register; the next item is taken while it
// waits only if the result is being taken in the same cycle, so a stalled
// receiver holds off i_item.
// Synchronous reset sets matrix_size to 64 and restarts loading; writing
// matrix_size over i_cfg_wr_en / i_cfg_wr_data also restarts loading, so
// all columns read as unloaded until loaded again. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module skyline_matrix_store (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    skm_item_if.sink            i_item,
    skm_result_if.source        o_result,
    input  wire logic           i_cfg_wr_en,
    input  wire skm_pkg::t_size i_cfg_wr_data
);
    import skm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INFO = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;

    logic [1:0] r_state, n_state;
    t_size      r_size, n_size;
    t_idx       r_next_row, n_next_row;
    t_size      r_next_col, n_next_col;
    logic       r_nz, n_nz;
    t_base      r_cur_base, n_cur_base;
    t_idx       r_cur_h, n_cur_h;
    t_idx       r_lk_row, n_lk_row;
    t_idx       r_lk_col, n_lk_col;
    logic       r_lk_hit, n_lk_hit;
    logic       r_out_valid, n_out_valid;
    t_word      r_out_value, n_out_value;
    t_err       r_out_err, n_out_err;

    logic  in_fire, out_free;
    t_size size_used;
    logic  range_err, order_err, unloaded, do_store;
    t_idx  lo_idx, hi_idx, diag_off, eff_h, lk_dist;

    logic            info_wr_en, info_rd_en;
    logic [INFO_W-1:0] info_wr_data, info_rd_data;
    t_base           info_base;
    t_idx            info_h;
    logic            pack_wr_en, pack_rd_en;
    t_paddr          pack_wr_addr, pack_rd_addr;
    t_word           pack_rd_data;

    assign out_free  = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == ST_IDLE) && out_free;
    assign in_fire   = i_item.valid && i_item.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.read_value = r_out_value;
    assign o_result.error_code = r_out_err;

    always_comb begin
        if (r_size == '0) begin
            size_used = t_size'(1);
        end else if (r_size > t_size'(MAX_SIZE)) begin
            size_used = t_size'(MAX_SIZE);
        end else begin
            size_used = r_size;
        end
    end

    assign range_err = ({1'b0, i_item.row_index} >= size_used)
                    || ({1'b0, i_item.col_index} >= size_used);
    assign order_err = (r_next_col >= size_used)
                    || (i_item.row_index != r_next_row)
                    || ({1'b0, i_item.col_index} != r_next_col);
    assign diag_off  = i_item.col_index - i_item.row_index;
    assign do_store  = r_nz || (i_item.row_index == i_item.col_index)
                    || !word_is_zero(i_item.element_value);
    assign eff_h     = r_nz ? r_cur_h : diag_off;

    assign lo_idx   = (i_item.row_index > i_item.col_index) ? i_item.col_index
                                                             : i_item.row_index;
    assign hi_idx   = (i_item.row_index > i_item.col_index) ? i_item.row_index
                                                             : i_item.col_index;
    assign unloaded = {1'b0, hi_idx} >= r_next_col;

    assign {info_base, info_h} = info_rd_data;
    assign lk_dist = r_lk_col - r_lk_row;

    always_comb begin
        info_wr_en   = 1'b0;
        info_wr_data = {r_cur_base, diag_off};
        info_rd_en   = 1'b0;
        pack_wr_en   = 1'b0;
        pack_wr_addr = PACK_AW'(r_cur_base) + PACK_AW'(diag_off);
        pack_rd_en   = 1'b0;
        pack_rd_addr = PACK_AW'(info_base) + PACK_AW'(lk_dist);

        n_state     = r_state;
        n_size      = r_size;
        n_next_row  = r_next_row;
        n_next_col  = r_next_col;
        n_nz        = r_nz;
        n_cur_base  = r_cur_base;
        n_cur_h     = r_cur_h;
        n_lk_row    = r_lk_row;
        n_lk_col    = r_lk_col;
        n_lk_hit    = r_lk_hit;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (range_err) begin
                        n_out_valid = 1'b1;
                        n_out_value = '0;
                        n_out_err   = ERR_RANGE;
                    end else if (i_item.action == ACT_LOAD) begin
                        n_out_valid = 1'b1;
                        n_out_value = '0;
                        if (order_err) begin
                            n_out_err = ERR_ORDER;
                        end else begin
                            n_out_err = ERR_OK;
                            if (do_store) begin
                                pack_wr_en = 1'b1;
                                if (!r_nz) begin
                                    info_wr_en = 1'b1;
                                    n_cur_h    = diag_off;
                                    n_nz       = 1'b1;
                                end
                            end
                            if (i_item.row_index == i_item.col_index) begin
                                n_next_col = r_next_col + t_size'(1);
                                n_next_row = '0;
                                n_nz       = 1'b0;
                                n_cur_base = r_cur_base + BASE_W'(eff_h) + t_base'(1);
                            end else begin
                                n_next_row = i_item.row_index + t_idx'(1);
                            end
                        end
                    end else if (unloaded) begin
                        n_out_valid = 1'b1;
                        n_out_value = '0;
                        n_out_err   = ERR_UNLOADED;
                    end else begin
                        info_rd_en = 1'b1;
                        n_lk_row   = lo_idx;
                        n_lk_col   = hi_idx;
                        n_state    = ST_INFO;
                    end
                end
            end
            ST_INFO: begin
                n_lk_hit   = lk_dist <= info_h;
                pack_rd_en = lk_dist <= info_h;
                n_state    = ST_DATA;
            end
            ST_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_lk_hit ? pack_rd_data : '0;
                    n_out_err   = ERR_OK;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_size     = i_cfg_wr_data;
            n_next_row = '0;
            n_next_col = '0;
            n_nz       = 1'b0;
            n_cur_base = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= t_size'(MAX_SIZE);
            r_next_row  <= '0;
            r_next_col  <= '0;
            r_nz        <= 1'b0;
            r_cur_base  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_next_row  <= n_next_row;
            r_next_col  <= n_next_col;
            r_nz        <= n_nz;
            r_cur_base  <= n_cur_base;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_h     <= n_cur_h;
        r_lk_row    <= n_lk_row;
        r_lk_col    <= n_lk_col;
        r_lk_hit    <= n_lk_hit;
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
    end

    // per-column base and height
    skm_ram #(
        .WIDTH (INFO_W),
        .DEPTH (MAX_SIZE)
    ) u_info_ram (
        .i_clk     (i_clk),
        .i_wr_en   (info_wr_en),
        .i_wr_addr (i_item.col_index),
        .i_wr_data (info_wr_data),
        .i_rd_en   (info_rd_en),
        .i_rd_addr (hi_idx),
        .o_rd_data (info_rd_data)
    );

    // packed skyline words
    skm_ram #(
        .WIDTH (64),
        .DEPTH (PACK_DEPTH)
    ) u_pack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pack_wr_en),
        .i_wr_addr (pack_wr_addr),
        .i_wr_data (i_item.element_value),
        .i_rd_en   (pack_rd_en),
        .i_rd_addr (pack_rd_addr),
        .o_rd_data (pack_rd_data)
    );

endmodule

`default_nettype wire
